FILE: design/sfu_pkg.sv
// Shared types and constants for the spike frame unpacker.
// No dependencies; imported by every design module and the checker.
`default_nettype none

package sfu_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TWO_BYTE  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY = 8'd3;

  localparam logic [15:0] WidthReset    = 16'd255;
  localparam logic [15:0] LengthReset   = 16'd255;
  localparam logic [12:0] MaxDelayReset = 13'd250;

  localparam logic [1:0] ByteIdxLast = 2'd3;

  // t / 10 == (t * 52429) >> 19 for every 16-bit t
  localparam logic [16:0] DivTenMul   = 17'd52429;
  localparam int unsigned DivTenShift = 19;

  typedef enum logic [1:0] {
    KIND_SPIKE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_RECORDS = 3'b010,
    PH_DISCARD = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    OP_SPIKE      = 2'd0,
    OP_SPIKE_DONE = 2'd1,
    OP_DONE       = 2'd2,
    OP_ERROR      = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [12:0] delay;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic        two_byte_coords;
    logic [15:0] group_width;
    logic [15:0] group_length;
    logic [12:0] max_delay;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/sfu_front.sv
// Front end: assembles stream bytes into 4-byte groups, tracks frame state
// and classifies each record into a command, skipping the records left in a frame after an error. Depends on sfu_pkg.
`default_nettype none

module sfu_front import sfu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     q_full_i,
  input  wire logic [7:0] stream_byte_i,
  input  wire cfg_t     cfg_i,
  output cmd_req_t      push_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] left_q, left_d;
  logic [23:0] held_q, held_d;

  logic        accept;
  logic [31:0] word;
  logic [31:0] left_dec;
  logic [15:0] x_val, y_val, ts;
  logic [32:0] prod;
  logic [12:0] quot, dly;
  logic        range_err;

  assign accept   = in_valid_i && !q_full_i;
  assign word     = {stream_byte_i, held_q};
  assign left_dec = left_q - 32'd1;
  assign ts       = word[31:16];
  assign prod     = {17'd0, ts} * {16'd0, DivTenMul};
  assign quot     = prod[DivTenShift +: 13];

  always_comb begin
    if (cfg_i.two_byte_coords) begin
      x_val = word[15:0];
      y_val = word[31:16];
      dly   = '0;
    end else begin
      x_val = {8'd0, word[7:0]};
      y_val = {8'd0, word[15:8]};
      dly   = (quot > cfg_i.max_delay) ? 13'd0 : quot;
    end
  end

  assign range_err = (x_val > cfg_i.group_width) || (y_val > cfg_i.group_length);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    left_d  = left_q;
    held_d  = held_q;
    push_o  = '0;
    push_o.cmd.op = OP_DONE;
    if (accept) begin
      if (idx_q != ByteIdxLast) begin
        if (phase_q != PH_DISCARD) begin
          held_d[8*idx_q +: 8] = stream_byte_i;
        end
        idx_d = idx_q + 2'd1;
      end else begin
        idx_d  = '0;
        held_d = '0;
        unique case (phase_q)
          PH_RECORDS: begin
            left_d = left_dec;
            push_o.valid = 1'b1;
            if (range_err) begin
              push_o.cmd.op = OP_ERROR;
              phase_d = (left_dec == 32'd0) ? PH_HEADER : PH_DISCARD;
            end else begin
              push_o.cmd.x_pos = x_val;
              push_o.cmd.y_pos = y_val;
              push_o.cmd.delay = dly;
              if (left_dec == 32'd0) begin
                push_o.cmd.op = OP_SPIKE_DONE;
                phase_d = PH_HEADER;
              end else begin
                push_o.cmd.op = OP_SPIKE;
              end
            end
          end
          PH_DISCARD: begin
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              phase_d = PH_HEADER;
            end
          end
          default: begin
            left_d = word;
            if (word == 32'd0) begin
              phase_d       = PH_HEADER;
              push_o.valid  = 1'b1;
              push_o.cmd.op = OP_DONE;
            end else begin
              phase_d = PH_RECORDS;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= '0;
      left_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfu_queue.sv
// Command queue between front and back end.
// Depends on sfu_pkg for the command types.
`default_nettype none

module sfu_queue import sfu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_req_t push_i,
  input  wire logic     pop_i,
  output cmd_t          head_o,
  output q_status_t     status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];
  assign do_pop         = pop_i && !status_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i.valid && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfu_back.sv
// Back end: turns queued commands into result items through an output
// register; a spike that closes a frame expands into two results. Uses sfu_pkg.
`default_nettype none

module sfu_back import sfu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_t      head_i,
  input  wire q_status_t status_i,
  output logic           pop_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output logic [1:0]     kind_o,
  output logic [15:0]    x_pos_o,
  output logic [15:0]    y_pos_o,
  output logic [12:0]    delay_o,
  output logic           last_o
);

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  kind_e       kind_q, kind_d;
  logic [15:0] x_q, x_d, y_q, y_d;
  logic [12:0] dly_q, dly_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    x_d     = x_q;
    y_d     = y_q;
    dly_d   = dly_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b0;
      if (pend_q) begin
        valid_d = 1'b1;
        pend_d  = 1'b0;
        kind_d  = KIND_DONE;
        x_d     = '0;
        y_d     = '0;
        dly_d   = '0;
        last_d  = 1'b1;
      end else if (!status_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        x_d     = '0;
        y_d     = '0;
        dly_d   = '0;
        last_d  = 1'b1;
        unique case (head_i.op)
          OP_SPIKE, OP_SPIKE_DONE: begin
            kind_d = KIND_SPIKE;
            x_d    = head_i.x_pos;
            y_d    = head_i.y_pos;
            dly_d  = head_i.delay;
            if (head_i.op == OP_SPIKE_DONE) begin
              last_d = 1'b0;
              pend_d = 1'b1;
            end
          end
          OP_DONE:  kind_d = KIND_DONE;
          OP_ERROR: kind_d = KIND_ERROR;
          default:  kind_d = KIND_ERROR;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    dly_q  <= dly_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign x_pos_o     = x_q;
  assign y_pos_o     = y_q;
  assign delay_o     = dly_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: design/spike_frame_unpacker.sv
// Spike frame unpacker top level: config registers, front end, command queue
// and back end. Depends on sfu_pkg, sfu_front, sfu_queue and sfu_back.
// Throughput: one stream byte per cycle; in_stall_o rises only while the queue
// holds Depth commands. A command goes through the queue, then the output register.
// Reset: frame state, queue and output valid cleared; config back to default values.
`default_nettype none

module spike_frame_unpacker import sfu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          stream_byte_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               kind_o,
  output logic [15:0]              x_pos_o,
  output logic [15:0]              y_pos_o,
  output logic [12:0]              delay_o,
  output logic                     last_o
);

  cfg_t      cfg_q, cfg_d;
  cmd_req_t  push;
  cmd_t      head;
  q_status_t qstat;
  logic      pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TWO_BYTE:  cfg_d.two_byte_coords = cfg_data_i[0];
        CFG_WIDTH:     cfg_d.group_width     = cfg_data_i;
        CFG_LENGTH:    cfg_d.group_length    = cfg_data_i;
        CFG_MAX_DELAY: cfg_d.max_delay       = cfg_data_i[12:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.two_byte_coords <= 1'b0;
      cfg_q.group_width     <= WidthReset;
      cfg_q.group_length    <= LengthReset;
      cfg_q.max_delay       <= MaxDelayReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = qstat.full;

  sfu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .q_full_i     (qstat.full),
    .stream_byte_i(stream_byte_i),
    .cfg_i        (cfg_q),
    .push_o       (push)
  );

  sfu_queue #(
    .Depth(Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(qstat)
  );

  sfu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .status_i   (qstat),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .kind_o     (kind_o),
    .x_pos_o    (x_pos_o),
    .y_pos_o    (y_pos_o),
    .delay_o    (delay_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

FILE: design/sfu_checker.sv
// Port-level checker for spike_frame_unpacker, bound to the top level.
// Depends on sfu_pkg for the result kind codes.
`default_nettype none

module sfu_checker import sfu_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [15:0] x_pos_o,
  input wire logic [15:0] y_pos_o,
  input wire logic [12:0] delay_o,
  input wire logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(x_pos_o)
      && $stable(y_pos_o) && $stable(delay_o) && $stable(last_o))
    else $error("stalled result changed");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_SPIKE || kind_o == KIND_DONE || kind_o == KIND_ERROR)
    else $error("undefined result kind");

  a_ctrl_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_SPIKE |-> last_o && x_pos_o == '0 && y_pos_o == '0
      && delay_o == '0)
    else $error("done/error result carries payload or is not last");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && kind_o == KIND_DONE)
    else $error("frame done did not follow final spike");

  a_notlast_spike: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == KIND_SPIKE)
    else $error("non-final result is not a spike");

endmodule

bind spike_frame_unpacker sfu_checker u_sfu_checker (.*);

`default_nettype wire
